### hdl/ppc_pkg.sv
// ----------------------------------------------------------------------------
// Pedal plausibility checker package
// Register map, fixed field widths, check ratios and the status item type.
// ----------------------------------------------------------------------------
package ppc_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 48;
    localparam int CAL_W       = 48;
    localparam int LEVEL_W     = 12;
    localparam int TIMEOUT_W   = 16;
    localparam int ELAPSED_W   = 8;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_ACCEL_ONE_CAL = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ACCEL_TWO_CAL = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_BRAKE_ONE_CAL = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_BRAKE_TWO_CAL = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_LIGHT_LEVEL   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_MECH_LEVEL    = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT       = 3'd6;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd100;

    // calibration word field positions
    localparam int CAL_MIN   = 0;
    localparam int CAL_MAX   = 1;
    localparam int CAL_START = 2;
    localparam int CAL_END   = 3;

    // agreement: 10% accelerator, 25% brake
    localparam int ACCEL_RATIO = 10;
    localparam int BRAKE_RATIO = 4;
    // cross fault sets above 25% travel, clears below 5%
    localparam int CROSS_SET_RATIO   = 4;
    localparam int CROSS_CLEAR_RATIO = 20;

    typedef struct packed {
        logic accel_ok;
        logic brake_ok;
        logic accel_brake_ok;
        logic pedals_valid;
        logic brake_light;
        logic mech_brake_active;
        logic drive_enable;
    } ppc_status_t;

endpackage

### hdl/pedal_sample_if.sv
// ----------------------------------------------------------------------------
// Pedal sample channel
// One item: four sensor readings, elapsed milliseconds, start button.
// ----------------------------------------------------------------------------
interface pedal_sample_if
    import ppc_pkg::*;
#(
    parameter int SAMPLE_BITS = 12
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] accel_one;
    logic [SAMPLE_BITS-1:0] accel_two;
    logic [SAMPLE_BITS-1:0] brake_one;
    logic [SAMPLE_BITS-1:0] brake_two;
    logic [ELAPSED_W-1:0]   elapsed_ms;
    logic                   start_button;

    modport source (
        output valid, accel_one, accel_two, brake_one, brake_two, elapsed_ms, start_button,
        input  ready
    );

    modport sink (
        input  valid, accel_one, accel_two, brake_one, brake_two, elapsed_ms, start_button,
        output ready
    );
endinterface

### hdl/pedal_status_if.sv
// ----------------------------------------------------------------------------
// Pedal status channel
// One item: plausibility flags and driver signals for one sample.
// ----------------------------------------------------------------------------
interface pedal_status_if;
    logic valid;
    logic ready;
    logic accel_ok;
    logic brake_ok;
    logic accel_brake_ok;
    logic pedals_valid;
    logic brake_light;
    logic mech_brake_active;
    logic drive_enable;

    modport source (
        output valid, accel_ok, brake_ok, accel_brake_ok, pedals_valid,
               brake_light, mech_brake_active, drive_enable,
        input  ready
    );

    modport sink (
        input  valid, accel_ok, brake_ok, accel_brake_ok, pedals_valid,
               brake_light, mech_brake_active, drive_enable,
        output ready
    );
endinterface

### hdl/ppc_agree.sv
// ----------------------------------------------------------------------------
// Sensor pair agreement test
// Positions n1/d1 and n2/d2 agree when RATIO*|n1*d2 - n2*d1| <= |d1*d2|.
// A zero span on either sensor fails the test.
// ----------------------------------------------------------------------------
module ppc_agree
    import ppc_pkg::*;
#(
    parameter int SAMPLE_BITS = 12,
    parameter int RATIO       = 10
)
(
    input  logic signed [SAMPLE_BITS:0] n1,
    input  logic signed [SAMPLE_BITS:0] d1,
    input  logic signed [SAMPLE_BITS:0] n2,
    input  logic signed [SAMPLE_BITS:0] d2,
    output logic                        agree
);
    localparam int PW = 2 * SAMPLE_BITS + 2;
    localparam int DW = PW + 1;
    localparam int SW = DW + 4;
    localparam logic [SW-1:0] RATIO_K = SW'(RATIO);

    logic signed [PW-1:0] cross_a;
    logic signed [PW-1:0] cross_b;
    logic signed [PW-1:0] span_prod;
    logic signed [DW-1:0] diff;
    logic        [DW-1:0] diff_mag;
    logic        [DW-1:0] span_mag;
    logic        [SW-1:0] scaled;

    always_comb
    begin
        cross_a   = n1 * d2;
        cross_b   = n2 * d1;
        span_prod = d1 * d2;
        diff      = DW'(cross_a) - DW'(cross_b);
        diff_mag  = diff[DW-1] ? DW'(-diff) : DW'(diff);
        span_mag  = span_prod[PW-1] ? DW'(-span_prod) : DW'(span_prod);
        scaled    = SW'(diff_mag) * RATIO_K;
        agree     = (d1 != '0) && (d2 != '0) && (scaled <= SW'(span_mag));
    end
endmodule

### hdl/pedal_plausibility_checker_core.sv
// ----------------------------------------------------------------------------
// Pedal plausibility checker core
// Range, agreement and accelerator-with-brake checks on each pedal sample,
// with an implausibility duration timer against a programmable timeout.
//
//   channel  | dir | handshake     | payload
//   ---------+-----+---------------+------------------------------------------
//   sample   | in  | valid / ready | four readings, elapsed_ms, start_button
//   status   | out | valid / ready | seven flag bits
//   cfg      | in  | write enable  | cfg_index, cfg_data (no read-back)
//
// One item per cycle sustained while status is ready; a sample passes the input
// register and then the result register on its way to status valid.
// The latch and duration counter update as an item moves to the result register.
// A stalled status side holds its item; a new sample is still taken while the
// input register can drain into the result register on the same edge. Reset
// clears the channel valids, latch, duration, calibration and level registers.
// ----------------------------------------------------------------------------
module pedal_plausibility_checker_core
    import ppc_pkg::*;
#(
    parameter int SAMPLE_BITS   = 12,
    parameter int DURATION_BITS = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    pedal_sample_if.sink           sample,
    pedal_status_if.source         status
);
    localparam int S    = SAMPLE_BITS;
    localparam int XW   = S + 6;
    localparam int CMPW = (DURATION_BITS > TIMEOUT_W) ? DURATION_BITS : TIMEOUT_W;
    localparam logic [DURATION_BITS-1:0] DUR_MAX = '1;
    localparam logic signed [XW-1:0] SET_K   = XW'(CROSS_SET_RATIO);
    localparam logic signed [XW-1:0] CLEAR_K = XW'(CROSS_CLEAR_RATIO);

    // configuration
    logic [CAL_W-1:0]     accel_one_cal_reg;
    logic [CAL_W-1:0]     accel_two_cal_reg;
    logic [CAL_W-1:0]     brake_one_cal_reg;
    logic [CAL_W-1:0]     brake_two_cal_reg;
    logic [LEVEL_W-1:0]   light_level_reg;
    logic [LEVEL_W-1:0]   mech_level_reg;
    logic [TIMEOUT_W-1:0] timeout_reg;

    // input register
    logic                 s1_valid_reg;
    logic [S-1:0]         a1_reg;
    logic [S-1:0]         a2_reg;
    logic [S-1:0]         b1_reg;
    logic [S-1:0]         b2_reg;
    logic [ELAPSED_W-1:0] elapsed_reg;
    logic                 start_reg;

    // state and result register
    logic                     latch_reg;
    logic                     latch_next;
    logic [DURATION_BITS-1:0] dur_reg;
    logic [DURATION_BITS-1:0] dur_next;
    logic                     out_valid_reg;
    ppc_status_t              status_reg;
    ppc_status_t              status_next;

    logic sample_take;
    logic advance;

    // calibration fields
    logic [63:0] a1_cal;
    logic [63:0] a2_cal;
    logic [63:0] b1_cal;
    logic [63:0] b2_cal;
    logic [S-1:0] b2_lo;
    logic [S-1:0] b2_hi;
    logic [S-1:0] light_level;
    logic [S-1:0] mech_level;

    logic signed [S:0] na1, da1, na2, da2, nb1, db1, nb2, db2;
    logic signed [XW-1:0] na1_w, da1_w, na2_w, da2_w;
    logic accel_agree;
    logic brake_agree;
    logic accel_range;
    logic brake_range;
    logic accel_ok;
    logic brake_ok;
    logic light;
    logic mech;
    logic cross_set;
    logic cross_clear;
    logic [DURATION_BITS:0] dur_sum;

    assign advance     = s1_valid_reg && (!out_valid_reg || status.ready);
    assign sample.ready = !s1_valid_reg || advance;
    assign sample_take = sample.valid && sample.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accel_one_cal_reg <= '0;
            accel_two_cal_reg <= '0;
            brake_one_cal_reg <= '0;
            brake_two_cal_reg <= '0;
            light_level_reg   <= '0;
            mech_level_reg    <= '0;
            timeout_reg       <= TIMEOUT_RESET;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                REG_ACCEL_ONE_CAL: accel_one_cal_reg <= cfg_data[CAL_W-1:0];
                REG_ACCEL_TWO_CAL: accel_two_cal_reg <= cfg_data[CAL_W-1:0];
                REG_BRAKE_ONE_CAL: brake_one_cal_reg <= cfg_data[CAL_W-1:0];
                REG_BRAKE_TWO_CAL: brake_two_cal_reg <= cfg_data[CAL_W-1:0];
                REG_LIGHT_LEVEL:   light_level_reg   <= cfg_data[LEVEL_W-1:0];
                REG_MECH_LEVEL:    mech_level_reg    <= cfg_data[LEVEL_W-1:0];
                REG_TIMEOUT:       timeout_reg       <= cfg_data[TIMEOUT_W-1:0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (sample_take)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_take)
        begin
            a1_reg      <= sample.accel_one;
            a2_reg      <= sample.accel_two;
            b1_reg      <= sample.brake_one;
            b2_reg      <= sample.brake_two;
            elapsed_reg <= sample.elapsed_ms;
            start_reg   <= sample.start_button;
        end
    end

    // fields past the 48 stored bits read as zero for wide samples
    always_comb
    begin
        a1_cal      = 64'(accel_one_cal_reg);
        a2_cal      = 64'(accel_two_cal_reg);
        b1_cal      = 64'(brake_one_cal_reg);
        b2_cal      = 64'(brake_two_cal_reg);
        light_level = S'(light_level_reg);
        mech_level  = S'(mech_level_reg);

        na1 = $signed({1'b0, a1_reg}) - $signed({1'b0, a1_cal[CAL_START*S +: S]});
        da1 = $signed({1'b0, a1_cal[CAL_END*S +: S]})
            - $signed({1'b0, a1_cal[CAL_START*S +: S]});
        na2 = $signed({1'b0, a2_reg}) - $signed({1'b0, a2_cal[CAL_START*S +: S]});
        da2 = $signed({1'b0, a2_cal[CAL_END*S +: S]})
            - $signed({1'b0, a2_cal[CAL_START*S +: S]});
        nb1 = $signed({1'b0, b1_reg}) - $signed({1'b0, b1_cal[CAL_START*S +: S]});
        db1 = $signed({1'b0, b1_cal[CAL_END*S +: S]})
            - $signed({1'b0, b1_cal[CAL_START*S +: S]});
        // brake two falls with travel
        nb2 = $signed({1'b0, b2_cal[CAL_START*S +: S]}) - $signed({1'b0, b2_reg});
        db2 = $signed({1'b0, b2_cal[CAL_START*S +: S]})
            - $signed({1'b0, b2_cal[CAL_END*S +: S]});

        if (b2_cal[CAL_MIN*S +: S] < b2_cal[CAL_MAX*S +: S])
        begin
            b2_lo = b2_cal[CAL_MIN*S +: S];
            b2_hi = b2_cal[CAL_MAX*S +: S];
        end
        else
        begin
            b2_lo = b2_cal[CAL_MAX*S +: S];
            b2_hi = b2_cal[CAL_MIN*S +: S];
        end

        accel_range = (a1_reg >= a1_cal[CAL_MIN*S +: S]) && (a1_reg <= a1_cal[CAL_MAX*S +: S])
                   && (a2_reg >= a2_cal[CAL_MIN*S +: S]) && (a2_reg <= a2_cal[CAL_MAX*S +: S]);
        brake_range = (b1_reg >= b1_cal[CAL_MIN*S +: S]) && (b1_reg <= b1_cal[CAL_MAX*S +: S])
                   && (b2_reg >= b2_lo) && (b2_reg <= b2_hi);
    end

    ppc_agree #(
        .SAMPLE_BITS (S),
        .RATIO       (ACCEL_RATIO)
    ) u_accel_agree (
        .n1    (na1),
        .d1    (da1),
        .n2    (na2),
        .d2    (da2),
        .agree (accel_agree)
    );

    ppc_agree #(
        .SAMPLE_BITS (S),
        .RATIO       (BRAKE_RATIO)
    ) u_brake_agree (
        .n1    (nb1),
        .d1    (db1),
        .n2    (nb2),
        .d2    (db2),
        .agree (brake_agree)
    );

    always_comb
    begin
        na1_w = XW'(na1);
        da1_w = XW'(da1);
        na2_w = XW'(na2);
        da2_w = XW'(da2);

        accel_ok = accel_range && accel_agree;
        brake_ok = brake_range && brake_agree;
        light    = b1_reg >= light_level;
        mech     = b1_reg >= mech_level;

        cross_set   = ((na1_w * SET_K) > da1_w) || ((na2_w * SET_K) > da2_w);
        cross_clear = ((na1_w * CLEAR_K) < da1_w) && ((na2_w * CLEAR_K) < da2_w);

        latch_next = latch_reg;
        if (cross_set && mech)
        begin
            latch_next = 1'b1;
        end
        else if (cross_clear)
        begin
            latch_next = 1'b0;
        end

        dur_sum = {1'b0, dur_reg} + (DURATION_BITS + 1)'(elapsed_reg);
        if (accel_ok && brake_ok && !latch_next)
        begin
            dur_next = '0;
        end
        else if (dur_sum[DURATION_BITS])
        begin
            dur_next = DUR_MAX;
        end
        else
        begin
            dur_next = dur_sum[DURATION_BITS-1:0];
        end

        status_next.accel_ok          = accel_ok;
        status_next.brake_ok          = brake_ok;
        status_next.accel_brake_ok    = !latch_next;
        status_next.pedals_valid      = CMPW'(dur_next) <= CMPW'(timeout_reg);
        status_next.brake_light       = light;
        status_next.mech_brake_active = mech;
        status_next.drive_enable      = start_reg && mech;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latch_reg     <= 1'b0;
            dur_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            latch_reg     <= latch_next;
            dur_reg       <= dur_next;
            out_valid_reg <= 1'b1;
        end
        else if (status.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            status_reg <= status_next;
        end
    end

    assign status.valid             = out_valid_reg;
    assign status.accel_ok          = status_reg.accel_ok;
    assign status.brake_ok          = status_reg.brake_ok;
    assign status.accel_brake_ok    = status_reg.accel_brake_ok;
    assign status.pedals_valid      = status_reg.pedals_valid;
    assign status.brake_light       = status_reg.brake_light;
    assign status.mech_brake_active = status_reg.mech_brake_active;
    assign status.drive_enable      = status_reg.drive_enable;

`ifndef SYNTHESIS
    // a passing item clears the timer
    a_dur_clear: assert property (@(posedge clk) disable iff (!rst_n)
        advance && accel_ok && brake_ok && !latch_next |=> dur_reg == '0)
        else $error("duration not cleared after passing item");

    // pedal pressed with brake active must latch the fault
    a_latch_set: assert property (@(posedge clk) disable iff (!rst_n)
        advance && cross_set && mech |=> latch_reg && !status.accel_brake_ok)
        else $error("cross fault not latched");

    // timer only grows or clears
    a_dur_mono: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (dur_reg == '0) || (dur_reg >= $past(dur_reg)))
        else $error("duration went backwards");

    // empty result register never blocks the input side
    a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> sample.ready)
        else $error("input stalled with empty result register");
`endif

endmodule
